// ----- src/vbsc_pkg.sv -----
package vbsc_pkg;

  localparam int GRID_SIZE_DEF    = 32;
  localparam int MAX_SUBSTEPS_DEF = 64;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int POS_W  = 24;
  localparam int MOT_W  = 22;
  localparam int HEXT_W = 19;
  localparam int CELL_W = 5;
  localparam int CFG_IDX_W = 2;

  // Wide internal coordinate: room for position, extents and snap math.
  localparam int ACC_W = 34;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_MOVE  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;
  localparam logic [1:0] FUNC_UNDEF = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_HEXT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEXT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEXT_Z = 2'd2;

  localparam logic [HEXT_W-1:0] HEXT_X_RST = 19'd19661;
  localparam logic [HEXT_W-1:0] HEXT_Y_RST = 19'd58982;
  localparam logic [HEXT_W-1:0] HEXT_Z_RST = 19'd19661;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEPS,
    ST_DIV,
    ST_AXIS,
    ST_BOUND,
    ST_SCAN,
    ST_WAIT,
    ST_SNAP,
    ST_DONE
  } state_t;

endpackage

// ----- src/voxel_box_sweep_collision.sv -----
// Voxel box sweep collision. Holds one solid bit per cell of a cubic grid in a
// memory with one write port and one read port and answers three kinds of
// item: a cell write, an overlap query for the configured box at a given
// center, and a move that sweeps the box in substeps of at most a quarter unit
// (more once the count saturates at MAX_SUBSTEPS), axis by axis, snapping one
// skin clear of any solid cell it enters. After reset the grid is cleared by a
// pass over all GRID_SIZE^3 cells before the first item is taken. An item is
// taken only when the block is idle, and the finished result waits in the
// output register so the next item can be taken meanwhile. A write or an
// undefined item goes straight to the result; a query bounds the box and tests
// its cells; a move divides the motion by the substep count and then, per
// substep and axis, skips an axis that does not move, else steps it, tests the
// box and snaps it when it hits. The memory read sets the cost of every box test.
module voxel_box_sweep_collision #(
  parameter int GRID_SIZE    = vbsc_pkg::GRID_SIZE_DEF,
  parameter int MAX_SUBSTEPS = vbsc_pkg::MAX_SUBSTEPS_DEF,
  parameter int FRAC_BITS    = vbsc_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // func[1:0], cell_x[6:2], cell_y[11:7], cell_z[16:12], cell_solid[17],
  // pos_x[41:18], pos_y[65:42], pos_z[89:66], motion_x[111:90],
  // motion_y[133:112], motion_z[155:134], zero fill up to 160 bits.
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_pos_x[23:0], new_pos_y[47:24], new_pos_z[71:48], blocked_x[72],
  // blocked_y[73], blocked_z[74], grounded[75], overlap[76], zero fill to 80.
  output logic [79:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [vbsc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [vbsc_pkg::HEXT_W-1:0]    cfg_wdata
);
  import vbsc_pkg::*;

  localparam int CW      = $clog2(GRID_SIZE);
  localparam int DEPTH   = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AW      = 3 * CW;
  localparam int SW      = $clog2(MAX_SUBSTEPS + 1);
  localparam int DIVW    = MOT_W;
  localparam int BW      = $clog2(DIVW + 1);
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint SKIN = (ONE + 5000) / 10000;
  localparam int STEP_SH = FRAC_BITS - 2;
  localparam logic signed [ACC_W-1:0] SKIN_A = ACC_W'(SKIN);
  localparam logic signed [ACC_W-1:0] PMAX = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] PMIN = -ACC_W'(8388608);
  localparam logic [AW:0] DEPTH_C = (AW+1)'(DEPTH);
  localparam logic [SW-1:0] MAXS = SW'(MAX_SUBSTEPS);

  logic mem_r [DEPTH];
  logic mem_rd_r;
  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic mem_wd;

  state_t state_r, state_nxt;
  logic [AW:0] clr_r, clr_nxt;
  logic [HEXT_W-1:0] hext_r [3];

  logic [1:0] func_r, func_nxt;
  logic signed [ACC_W-1:0] p_r [3];
  logic signed [ACC_W-1:0] p_nxt [3];
  logic signed [MOT_W-1:0] m_r [3];
  logic signed [MOT_W-1:0] d_r [3];
  logic signed [MOT_W-1:0] d_nxt [3];
  logic [SW-1:0] steps_r, steps_nxt, sidx_r, sidx_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic [DIVW-1:0] quo_r, quo_nxt;
  logic [DIVW:0] rem_r, rem_nxt;
  logic [BW-1:0] bit_r, bit_nxt;
  logic [CW-1:0] lo_r [3];
  logic [CW-1:0] hi_r [3];
  logic [CW-1:0] lo_nxt [3];
  logic [CW-1:0] hi_nxt [3];
  logic [CW-1:0] c_r [3];
  logic [CW-1:0] c_nxt [3];
  logic scan_last_r, scan_last_nxt;
  logic [2:0] blk_r, blk_nxt;
  logic gnd_r, gnd_nxt, ovl_r, ovl_nxt;
  logic [79:0] out_r, out_nxt;
  logic ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem_r[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hext_r[0] <= HEXT_X_RST;
      hext_r[1] <= HEXT_Y_RST;
      hext_r[2] <= HEXT_Z_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HEXT_X: hext_r[0] <= cfg_wdata;
        REG_HEXT_Y: hext_r[1] <= cfg_wdata;
        REG_HEXT_Z: hext_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    for (int i = 0; i < 3; i++) begin
      p_r[i]  <= p_nxt[i];
      d_r[i]  <= d_nxt[i];
      lo_r[i] <= lo_nxt[i];
      hi_r[i] <= hi_nxt[i];
      c_r[i]  <= c_nxt[i];
    end
    if (state_r == ST_IDLE && in_tvalid) begin
      m_r[0] <= in_tdata[111:90];
      m_r[1] <= in_tdata[133:112];
      m_r[2] <= in_tdata[155:134];
    end
    steps_r <= steps_nxt;
    sidx_r <= sidx_nxt;
    ax_r <= ax_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
    scan_last_r <= scan_last_nxt;
    blk_r <= blk_nxt;
    gnd_r <= gnd_nxt;
    ovl_r <= ovl_nxt;
    out_r <= out_nxt;
  end

  function automatic logic [CW-1:0] clamp_lo(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v >>> FRAC_BITS;
    if (c < 0) clamp_lo = '0;
    else if (c > ACC_W'(GRID_SIZE - 1)) clamp_lo = CW'(GRID_SIZE - 1);
    else clamp_lo = c[CW-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
    if (v > PMAX) sat_pos = PMAX;
    else if (v < PMIN) sat_pos = PMIN;
    else sat_pos = v;
  endfunction

  logic signed [ACC_W-1:0] hx, lo_v, hi_v, pa, snap_v;
  logic signed [ACC_W-1:0] lo_c, hi_c;
  logic signed [ACC_W-1:0] sat_x, sat_y, sat_z;
  logic [MOT_W-1:0] amax, a0, a1, a2;
  logic [MOT_W-1:0] sdiv;
  logic signed [MOT_W-1:0] dax;
  logic [DIVW:0] rem_sh;
  logic last_x, last_y, last_z;
  logic [AW-1:0] scan_addr;
  logic [1:0] ax_i;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    func_nxt = func_r;
    steps_nxt = steps_r;
    sidx_nxt = sidx_r;
    ax_nxt = ax_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    bit_nxt = bit_r;
    scan_last_nxt = scan_last_r;
    blk_nxt = blk_r;
    gnd_nxt = gnd_r;
    ovl_nxt = ovl_r;
    out_nxt = out_r;
    ov_nxt = ov_r;
    for (int i = 0; i < 3; i++) begin
      p_nxt[i] = p_r[i];
      d_nxt[i] = d_r[i];
      lo_nxt[i] = lo_r[i];
      hi_nxt[i] = hi_r[i];
      c_nxt[i] = c_r[i];
    end
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = 1'b0;
    in_tready = 1'b0;

    a0 = m_r[0][MOT_W-1] ? MOT_W'(-m_r[0]) : MOT_W'(m_r[0]);
    a1 = m_r[1][MOT_W-1] ? MOT_W'(-m_r[1]) : MOT_W'(m_r[1]);
    a2 = m_r[2][MOT_W-1] ? MOT_W'(-m_r[2]) : MOT_W'(m_r[2]);
    amax = (a0 > a1) ? a0 : a1;
    amax = (amax > a2) ? amax : a2;

    ax_i = (ax_r == 2'd3) ? 2'd0 : ax_r;
    dax = m_r[ax_i];
    sdiv = dax[MOT_W-1] ? MOT_W'(-dax) : MOT_W'(dax);
    rem_sh = {rem_r[DIVW-1:0], sdiv[BW'(DIVW - 1) - bit_r]};

    hx = ACC_W'(hext_r[ax_i]);
    pa = p_r[ax_i];
    lo_c = '0;
    hi_c = '0;
    lo_v = '0;
    hi_v = '0;
    snap_v = '0;
    sat_x = sat_pos(p_r[0]);
    sat_y = sat_pos(p_r[1]);
    sat_z = sat_pos(p_r[2]);

    last_x = (c_r[0] == hi_r[0]);
    last_y = (c_r[1] == hi_r[1]);
    last_z = (c_r[2] == hi_r[2]);
    scan_addr = {c_r[2], c_r[1], c_r[0]};
    mem_ra = scan_addr;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r[AW-1:0];
        mem_wd = 1'b0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == DEPTH_C - 1'b1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          func_nxt = in_tdata[1:0];
          p_nxt[0] = ACC_W'(signed'(in_tdata[41:18]));
          p_nxt[1] = ACC_W'(signed'(in_tdata[65:42]));
          p_nxt[2] = ACC_W'(signed'(in_tdata[89:66]));
          blk_nxt = '0;
          gnd_nxt = 1'b0;
          ovl_nxt = 1'b0;
          unique case (in_tdata[1:0])
            FUNC_WRITE: begin
              if (9'(in_tdata[6:2]) < 9'(GRID_SIZE) &&
                  9'(in_tdata[11:7]) < 9'(GRID_SIZE) &&
                  9'(in_tdata[16:12]) < 9'(GRID_SIZE)) begin
                mem_we = 1'b1;
                mem_wa = {CW'(in_tdata[16:12]), CW'(in_tdata[11:7]), CW'(in_tdata[6:2])};
                mem_wd = in_tdata[17];
              end
              state_nxt = ST_DONE;
            end
            FUNC_MOVE: state_nxt = ST_STEPS;
            FUNC_QUERY: begin
              ax_nxt = 2'd3;
              state_nxt = ST_BOUND;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_STEPS: begin
        // ceil(longest / quarter unit), at least one, saturated.
        if (amax == '0) steps_nxt = SW'(1);
        else if (((amax - 1'b1) >> STEP_SH) >= MOT_W'(MAX_SUBSTEPS)) steps_nxt = MAXS;
        else steps_nxt = SW'(((amax - 1'b1) >> STEP_SH) + 1'b1);
        ax_nxt = 2'd0;
        quo_nxt = '0;
        rem_nxt = '0;
        bit_nxt = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // Restoring division of |motion| by the substep count, one bit a cycle.
        if (rem_sh >= (DIVW+1)'(steps_r)) begin
          rem_nxt = rem_sh - (DIVW+1)'(steps_r);
          quo_nxt = {quo_r[DIVW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[DIVW-2:0], 1'b0};
        end
        bit_nxt = bit_r + 1'b1;
        if (bit_r == BW'(DIVW - 1)) begin
          d_nxt[ax_i] = dax[MOT_W-1] ? MOT_W'(-quo_nxt) : MOT_W'(quo_nxt);
          bit_nxt = '0;
          quo_nxt = '0;
          rem_nxt = '0;
          if (ax_r == 2'd2) begin
            ax_nxt = 2'd0;
            sidx_nxt = '0;
            state_nxt = ST_AXIS;
          end else begin
            ax_nxt = ax_r + 1'b1;
          end
        end
      end
      ST_AXIS: begin
        if (d_r[ax_i] == '0) begin
          if (ax_r == 2'd2) begin
            ax_nxt = 2'd0;
            sidx_nxt = sidx_r + 1'b1;
            if (sidx_r + 1'b1 == steps_r) state_nxt = ST_DONE;
          end else begin
            ax_nxt = ax_r + 1'b1;
          end
        end else begin
          p_nxt[ax_i] = p_r[ax_i] + ACC_W'(d_r[ax_i]);
          state_nxt = ST_BOUND;
        end
      end
      ST_BOUND: begin
        for (int i = 0; i < 3; i++) begin
          lo_v = p_r[i] - ACC_W'(hext_r[i]) + SKIN_A;
          hi_v = p_r[i] + ACC_W'(hext_r[i]) - SKIN_A;
          lo_nxt[i] = clamp_lo(lo_v);
          hi_nxt[i] = clamp_lo(hi_v);
          c_nxt[i] = clamp_lo(lo_v);
          lo_c = lo_v >>> FRAC_BITS;
          hi_c = hi_v >>> FRAC_BITS;
          if (hi_c < 0 || lo_c > ACC_W'(GRID_SIZE - 1) || lo_c > hi_c)
            scan_last_nxt = 1'b1;
        end
        state_nxt = ST_SCAN;
        // Empty box: report no hit without reading the grid.
        begin
          logic emp;
          emp = 1'b0;
          for (int i = 0; i < 3; i++) begin
            lo_v = p_r[i] - ACC_W'(hext_r[i]) + SKIN_A;
            hi_v = p_r[i] + ACC_W'(hext_r[i]) - SKIN_A;
            lo_c = lo_v >>> FRAC_BITS;
            hi_c = hi_v >>> FRAC_BITS;
            if (hi_c < 0 || lo_c > ACC_W'(GRID_SIZE - 1) || lo_c > hi_c) emp = 1'b1;
          end
          scan_last_nxt = 1'b0;
          if (emp) begin
            if (ax_r == 2'd3) begin
              ovl_nxt = 1'b0;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_WAIT;
              scan_last_nxt = 1'b1;
              ovl_nxt = 1'b0;
            end
          end
        end
      end
      ST_SCAN: begin
        // Issue one read; ST_WAIT checks it next cycle, before any further read.
        scan_last_nxt = last_x && last_y && last_z;
        ovl_nxt = 1'b0;
        state_nxt = ST_WAIT;
        if (!last_x) c_nxt[0] = c_r[0] + 1'b1;
        else begin
          c_nxt[0] = lo_r[0];
          if (!last_y) c_nxt[1] = c_r[1] + 1'b1;
          else begin
            c_nxt[1] = lo_r[1];
            c_nxt[2] = c_r[2] + 1'b1;
          end
        end
        ovl_nxt = 1'b1;
      end
      ST_WAIT: begin
        // ovl_r set means a read is pending in mem_rd_r.
        if (ovl_r && mem_rd_r) begin
          if (ax_r == 2'd3) begin
            ovl_nxt = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SNAP;
          end
        end else if (scan_last_r || !ovl_r) begin
          ovl_nxt = 1'b0;
          if (ax_r == 2'd3) state_nxt = ST_DONE;
          else if (ax_r == 2'd2) begin
            ax_nxt = 2'd0;
            sidx_nxt = sidx_r + 1'b1;
            state_nxt = (sidx_r + 1'b1 == steps_r) ? ST_DONE : ST_AXIS;
          end else begin
            ax_nxt = ax_r + 1'b1;
            state_nxt = ST_AXIS;
          end
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SNAP: begin
        ovl_nxt = 1'b0;
        if (!d_r[ax_i][MOT_W-1]) begin
          snap_v = ((pa + hx) >>> FRAC_BITS) <<< FRAC_BITS;
          p_nxt[ax_i] = snap_v - hx - SKIN_A;
        end else begin
          snap_v = -(((-(pa - hx)) >>> FRAC_BITS) <<< FRAC_BITS);
          p_nxt[ax_i] = snap_v + hx + SKIN_A;
          if (ax_i == 2'd1) gnd_nxt = 1'b1;
        end
        blk_nxt[ax_i] = 1'b1;
        if (ax_r == 2'd2) begin
          ax_nxt = 2'd0;
          sidx_nxt = sidx_r + 1'b1;
          state_nxt = (sidx_r + 1'b1 == steps_r) ? ST_DONE : ST_AXIS;
        end else begin
          ax_nxt = ax_r + 1'b1;
          state_nxt = ST_AXIS;
        end
      end
      ST_DONE: begin
        if (!ov_r || out_tready) begin
          out_nxt = '0;
          out_nxt[23:0]  = sat_x[POS_W-1:0];
          out_nxt[47:24] = sat_y[POS_W-1:0];
          out_nxt[71:48] = sat_z[POS_W-1:0];
          out_nxt[72] = blk_r[0];
          out_nxt[73] = blk_r[1];
          out_nxt[74] = blk_r[2];
          out_nxt[75] = gnd_r;
          out_nxt[76] = (func_r == FUNC_QUERY) && ovl_r;
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (ov_r && out_tready && state_r != ST_DONE) ov_nxt = 1'b0;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == ST_IDLE)) else $error("ready outside idle");
  a_no_ready_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_tvalid) else $error("result during clear");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");

endmodule

// ----- tb/sv/voxel_box_sweep_collision_test.sv -----
`timescale 1ns / 1ps

module voxel_box_sweep_collision_test;
  import vbsc_pkg::*;

  localparam longint UNIT = 65536;
  localparam longint SKIN = 7;
  localparam int GRID = 32;

  typedef struct packed {
    logic [3:0]        fill;
    logic signed [21:0] mz;
    logic signed [21:0] my;
    logic signed [21:0] mx;
    logic signed [23:0] pz;
    logic signed [23:0] py;
    logic signed [23:0] px;
    logic               solid;
    logic [4:0]         cz;
    logic [4:0]         cy;
    logic [4:0]         cx;
    logic [1:0]         fn;
  } voxel_cmd_t;

  typedef struct packed {
    logic [2:0]         fill;
    logic               ovl;
    logic               gnd;
    logic               bz;
    logic               by;
    logic               bx;
    logic signed [23:0] nz;
    logic signed [23:0] ny;
    logic signed [23:0] nx;
  } sweep_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [159:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [HEXT_W-1:0] cfg_wdata = '0;

  voxel_box_sweep_collision dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  bit solid_grid [GRID*GRID*GRID];
  longint box_half [3];
  longint box_pos [3];
  bit hit_axis [3];
  bit on_ground;

  sweep_res_t pending_results [$];
  int errors = 0;
  int sent_items = 0;
  int moves_seen = 0;
  int blocks_seen = 0;
  int grounds_seen = 0;
  int overlaps_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic longint floor_u(longint v);
    return v >>> 16;
  endfunction

  function automatic longint ceil_u(longint v);
    return -((-v) >>> 16);
  endfunction

  function automatic bit box_touches();
    longint lo [3];
    longint hi [3];
    for (int a = 0; a < 3; a++) begin
      lo[a] = floor_u(box_pos[a] - box_half[a] + SKIN);
      hi[a] = floor_u(box_pos[a] + box_half[a] - SKIN);
      if (lo[a] < 0) lo[a] = 0;
      if (hi[a] > GRID - 1) hi[a] = GRID - 1;
      if (lo[a] > hi[a]) return 1'b0;
    end
    for (longint z = lo[2]; z <= hi[2]; z++)
      for (longint y = lo[1]; y <= hi[1]; y++)
        for (longint x = lo[0]; x <= hi[0]; x++)
          if (solid_grid[(z * GRID + y) * GRID + x]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic signed [23:0] clamp_pos(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic sweep_res_t predict_sweep(voxel_cmd_t c);
    sweep_res_t r;
    longint m [3];
    longint d [3];
    longint longest;
    longint steps;
    longint v;
    r = '0;
    box_pos[0] = longint'(c.px);
    box_pos[1] = longint'(c.py);
    box_pos[2] = longint'(c.pz);
    m[0] = longint'(c.mx);
    m[1] = longint'(c.my);
    m[2] = longint'(c.mz);
    hit_axis = '{0, 0, 0};
    on_ground = 1'b0;
    case (c.fn)
      FUNC_WRITE: solid_grid[(int'(c.cz) * GRID + int'(c.cy)) * GRID + int'(c.cx)] = c.solid;
      FUNC_MOVE: begin
        longest = 0;
        for (int a = 0; a < 3; a++) begin
          v = (m[a] < 0) ? -m[a] : m[a];
          if (v > longest) longest = v;
        end
        steps = (longest + UNIT / 4 - 1) / (UNIT / 4);
        if (steps < 1) steps = 1;
        if (steps > MAX_SUBSTEPS_DEF) steps = MAX_SUBSTEPS_DEF;
        for (int a = 0; a < 3; a++) d[a] = m[a] / steps;
        for (longint s = 0; s < steps; s++) begin
          for (int a = 0; a < 3; a++) begin
            if (d[a] != 0) begin
              box_pos[a] += d[a];
              if (box_touches()) begin
                if (d[a] > 0)
                  box_pos[a] = floor_u(box_pos[a] + box_half[a]) * UNIT - box_half[a] - SKIN;
                else
                  box_pos[a] = ceil_u(box_pos[a] - box_half[a]) * UNIT + box_half[a] + SKIN;
                hit_axis[a] = 1'b1;
                if (a == 1 && d[a] < 0) on_ground = 1'b1;
              end
            end
          end
        end
      end
      FUNC_QUERY: r.ovl = box_touches();
      default: ;
    endcase
    r.nx = clamp_pos(box_pos[0]);
    r.ny = clamp_pos(box_pos[1]);
    r.nz = clamp_pos(box_pos[2]);
    r.bx = hit_axis[0];
    r.by = hit_axis[1];
    r.bz = hit_axis[2];
    r.gnd = on_ground;
    return r;
  endfunction

  function automatic voxel_cmd_t mk_cmd(logic [1:0] fn, int cx, int cy, int cz, bit sol,
                                        longint px, longint py, longint pz,
                                        longint mx, longint my, longint mz);
    voxel_cmd_t c;
    c = '0;
    c.fn = fn;
    c.cx = cx[4:0];
    c.cy = cy[4:0];
    c.cz = cz[4:0];
    c.solid = sol;
    c.px = px[23:0];
    c.py = py[23:0];
    c.pz = pz[23:0];
    c.mx = mx[21:0];
    c.my = my[21:0];
    c.mz = mz[21:0];
    return c;
  endfunction

  function automatic sweep_res_t echo_of(voxel_cmd_t c);
    sweep_res_t r;
    r = '0;
    r.nx = c.px;
    r.ny = c.py;
    r.nz = c.pz;
    return r;
  endfunction

  function automatic longint rand_pos(bit wide);
    if (wide) return longint'($urandom_range(0, 16777215)) - 8388608;
    return longint'($urandom_range(5 * UNIT, 19 * UNIT));
  endfunction

  function automatic longint rand_motion();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return 0;
    if (sel < 70) return longint'($urandom_range(0, 2 * UNIT)) - UNIT;
    return longint'($urandom_range(0, 2097152)) - 1048576;
  endfunction

  function automatic voxel_cmd_t rand_cmd();
    int sel;
    bit wide;
    voxel_cmd_t c;
    sel = $urandom_range(0, 99);
    wide = ($urandom_range(0, 9) == 0);
    c = mk_cmd(FUNC_MOVE, 0, 0, 0, 0, rand_pos(wide), rand_pos(wide), rand_pos(wide),
               rand_motion(), rand_motion(), rand_motion());
    if (sel < 30) begin
      c.fn = FUNC_WRITE;
      if ($urandom_range(0, 4) == 0) begin
        c.cx = 5'($urandom_range(0, 31));
        c.cy = 5'($urandom_range(0, 31));
        c.cz = 5'($urandom_range(0, 31));
      end else begin
        c.cx = 5'($urandom_range(6, 17));
        c.cy = 5'($urandom_range(6, 17));
        c.cz = 5'($urandom_range(6, 17));
      end
      c.solid = ($urandom_range(0, 3) != 0);
    end else if (sel < 80) begin
      c.fn = FUNC_MOVE;
    end else if (sel < 95) begin
      c.fn = FUNC_QUERY;
    end else begin
      c.fn = FUNC_UNDEF;
    end
    return c;
  endfunction

  task automatic send_cmd(voxel_cmd_t c, bit known, sweep_res_t exp_res);
    sweep_res_t pred;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    pred = predict_sweep(c);
    pending_results.push_back(known ? exp_res : pred);
    in_tvalid <= 1'b1;
    in_tdata <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_box(longint hx, longint hy, longint hz);
    longint vals [3];
    vals = '{hx, hy, hz};
    drain();
    for (int a = 0; a < 3; a++) begin
      cfg_we <= 1'b1;
      cfg_addr <= (a == 0) ? REG_HEXT_X : (a == 1) ? REG_HEXT_Y : REG_HEXT_Z;
      cfg_wdata <= vals[a][HEXT_W-1:0];
      box_half[a] = vals[a];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n)
      out_tready <= 1'b0;
    else
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    sweep_res_t got;
    sweep_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz) begin
          $display("%0t: position expected (%0d,%0d,%0d) actual (%0d,%0d,%0d)", $time,
                   want.nx, want.ny, want.nz, got.nx, got.ny, got.nz);
          errors++;
        end
        if ({got.bx, got.by, got.bz, got.gnd, got.ovl} !==
            {want.bx, want.by, want.bz, want.gnd, want.ovl}) begin
          $display("%0t: flags bx,by,bz,gnd,ovl expected %b actual %b", $time,
                   {want.bx, want.by, want.bz, want.gnd, want.ovl},
                   {got.bx, got.by, got.bz, got.gnd, got.ovl});
          errors++;
        end
        if (got.bx || got.by || got.bz) blocks_seen++;
        if (got.gnd) grounds_seen++;
        if (got.ovl) overlaps_seen++;
      end
    end
  end

  initial begin
    #400_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    voxel_cmd_t plan [$];
    bit plan_known [$];
    sweep_res_t plan_exp [$];
    voxel_cmd_t c;
    longint boxes [6][3];
    int counts [6];
    int done;

    box_half = '{19661, 58982, 19661};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    c = mk_cmd(FUNC_QUERY, 0, 0, 0, 0, 8388607, -8388608, 0, 0, 0, 0);
    plan.push_back(c); plan_known.push_back(1); plan_exp.push_back(echo_of(c));
    c = mk_cmd(FUNC_UNDEF, 31, 31, 31, 1, -1, -1, -1, -1, -1, -1);
    plan.push_back(c); plan_known.push_back(1); plan_exp.push_back(echo_of(c));
    c = mk_cmd(FUNC_MOVE, 0, 0, 0, 0, 5 * UNIT, 5 * UNIT, 5 * UNIT, UNIT / 2, -UNIT / 2, 0);
    plan.push_back(c); plan_known.push_back(0); plan_exp.push_back('0);
    for (int i = 0; i < 5; i++) begin
      c = mk_cmd(FUNC_WRITE, (i == 1) ? 4 : (i == 2) ? 6 : 5, 4,
                 (i == 3) ? 4 : (i == 4) ? 6 : 5, 1, 0, 0, 0, 0, 0, 0);
      plan.push_back(c); plan_known.push_back(1); plan_exp.push_back(echo_of(c));
    end
    c = mk_cmd(FUNC_WRITE, 31, 31, 31, 1, 0, 0, 0, 0, 0, 0);
    plan.push_back(c); plan_known.push_back(1); plan_exp.push_back(echo_of(c));
    c = mk_cmd(FUNC_WRITE, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    plan.push_back(c); plan_known.push_back(1); plan_exp.push_back(echo_of(c));
    c = mk_cmd(FUNC_WRITE, 9, 9, 9, 0, 0, 0, 0, 0, 0, 0);
    plan.push_back(c); plan_known.push_back(1); plan_exp.push_back(echo_of(c));
    c = mk_cmd(FUNC_MOVE, 0, 0, 0, 0, 5 * UNIT + UNIT / 2, 6 * UNIT, 5 * UNIT + UNIT / 2,
               0, -2 * UNIT, 0);
    plan.push_back(c); plan_known.push_back(0); plan_exp.push_back('0);
    c = mk_cmd(FUNC_MOVE, 0, 0, 0, 0, 3 * UNIT, 5 * UNIT, 5 * UNIT + UNIT / 2,
               3 * UNIT, 0, 0);
    plan.push_back(c); plan_known.push_back(0); plan_exp.push_back('0);
    c = mk_cmd(FUNC_MOVE, 0, 0, 0, 0, 31 * UNIT + UNIT / 2, 28 * UNIT, 31 * UNIT + UNIT / 2,
               0, 1048576, 0);
    plan.push_back(c); plan_known.push_back(0); plan_exp.push_back('0);
    c = mk_cmd(FUNC_MOVE, 0, 0, 0, 0, 2 * UNIT, 2 * UNIT, 2 * UNIT,
               -1048576, -1048576, -1048576);
    plan.push_back(c); plan_known.push_back(0); plan_exp.push_back('0);
    c = mk_cmd(FUNC_QUERY, 0, 0, 0, 0, UNIT / 5, UNIT / 5, UNIT / 5, 0, 0, 0);
    plan.push_back(c); plan_known.push_back(0); plan_exp.push_back('0);
    c = mk_cmd(FUNC_MOVE, 0, 0, 0, 0, 8388607 - 256, -8388608 + 256, 0,
               1048576, -1048576, 0);
    plan.push_back(c); plan_known.push_back(0); plan_exp.push_back('0);
    c = mk_cmd(FUNC_MOVE, 0, 0, 0, 0, 7 * UNIT, 7 * UNIT, 7 * UNIT, 0, 0, 0);
    plan.push_back(c); plan_known.push_back(0); plan_exp.push_back('0);
    c = mk_cmd(FUNC_QUERY, 0, 0, 0, 0, 5 * UNIT, 4 * UNIT + UNIT / 2, 5 * UNIT, 0, 0, 0);
    plan.push_back(c); plan_known.push_back(0); plan_exp.push_back('0);
    c = mk_cmd(FUNC_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    plan.push_back(c); plan_known.push_back(1); plan_exp.push_back(echo_of(c));

    for (int i = 0; i < plan.size(); i++) send_cmd(plan[i], plan_known[i], plan_exp[i]);

    boxes = '{'{19661, 58982, 19661}, '{0, 0, 0}, '{262144, 262144, 262144},
              '{0, 0, 0}, '{0, 0, 0}, '{65536, 32768, 131072}};
    counts = '{500, 150, 20, 400, 400, 280};
    done = 0;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 3 || ph == 4)
        for (int a = 0; a < 3; a++) boxes[ph][a] = longint'($urandom_range(0, 262144) / 4);
      set_box(boxes[ph][0], boxes[ph][1], boxes[ph][2]);
      for (int i = 0; i < counts[ph]; i++) begin
        if (done < 600) begin
          send_idle_pct = 14; recv_idle_pct = 47;
        end else if (done < 1200) begin
          send_idle_pct = 47; recv_idle_pct = 14;
        end else begin
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        if (i == 100) drain();
        if (i % 60 < 10 && ph != 2) begin
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        send_cmd(rand_cmd(), 1'b0, '0);
        done++;
      end
    end
    set_box(19661, 58982, 19661);
    drain();
    repeat (200) @(posedge clk);

    $display("Ran %0d items across six box sizes, from zero to four units half width.",
             sent_items);
    $display("Results blocked %0d moves, grounded %0d, and %0d queries overlapped.",
             blocks_seen, grounds_seen, overlaps_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
